// File: rtl/lprt_pkg.sv
`timescale 1ns / 1ps
// lprt_pkg: shared types, codes and helpers for the longest prefix route table
// no dependencies

package lprt_pkg;

  // operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_PRESENT = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_NONE    = 2'd3;

  // configuration register indexes
  localparam logic [7:0] CFG_DEFAULT_INTERFACE = 8'd0;
  localparam logic [7:0] CFG_DEFAULT_NEXT_HOP  = 8'd1;

  localparam logic [5:0] MAX_LEN = 6'd32;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] address;
    logic [5:0]  prefix_length;
    logic [7:0]  egress_interface;
    logic [31:0] hop_address;
  } lprt_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        matched;
    logic [5:0]  matched_length;
    logic [7:0]  route_interface;
    logic [31:0] route_next_hop;
  } lprt_result_t;

  typedef enum logic [2:0] {
    SCAN_CLEAR,
    SCAN_IDLE,
    SCAN_READ,
    SCAN_LAST,
    SCAN_DONE
  } lprt_state_t;

  // leading-ones mask for a prefix length of 0 to 32
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    len_mask = ~(32'hFFFF_FFFF >> len);
  endfunction

endpackage

// File: rtl/lprt_if.sv
`timescale 1ns / 1ps
// lprt_if: valid/ready channel interfaces for command, result and config
// no dependencies

interface lprt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] address;
  logic [5:0]  prefix_length;
  logic [7:0]  egress_interface;
  logic [31:0] hop_address;

  modport source (output valid, op, address, prefix_length, egress_interface, hop_address,
                  input ready);
  modport sink (input valid, op, address, prefix_length, egress_interface, hop_address,
                output ready);
endinterface

interface lprt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        matched;
  logic [5:0]  matched_length;
  logic [7:0]  route_interface;
  logic [31:0] route_next_hop;

  modport source (output valid, status, matched, matched_length, route_interface,
                  route_next_hop, input ready);
  modport sink (input valid, status, matched, matched_length, route_interface,
                route_next_hop, output ready);
endinterface

interface lprt_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/lprt_mem.sv
`timescale 1ns / 1ps
// lprt_mem: route entry memory, one write port and one registered read port
// no dependencies

module lprt_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 79
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lprt_scan.sv
`timescale 1ns / 1ps
// lprt_scan: sequencer that clears the table, scans every entry per operation
// and writes back add/delete updates; depends on lprt_pkg

module lprt_scan import lprt_pkg::*; #(
  parameter int TABLE_DEPTH    = 64,
  parameter int INTERFACE_BITS = 8,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int EW = 1 + 32 + 6 + INTERFACE_BITS + 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lprt_cmd_t     cmd,
  input  logic [7:0]    def_if,
  input  logic [31:0]   def_hop,
  input  logic          out_space,
  output logic          done,
  output lprt_result_t  res,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [EW-1:0] mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [EW-1:0] mem_rdata
);

  localparam logic [AW-1:0] LastIdx = AW'(TABLE_DEPTH - 1);

  lprt_state_t state_r, state_nxt;
  logic [AW-1:0] ridx_r;
  logic [AW-1:0] didx_r;
  logic          rvalid_r;

  // captured command
  logic [1:0]                op_r;
  logic [31:0]               addr_r;
  logic [31:0]               key_r;
  logic [5:0]                len_r;
  logic [INTERFACE_BITS-1:0] if_r;
  logic [31:0]               hop_r;

  // scan accumulators
  logic                      hit_r;
  logic [AW-1:0]             hit_idx_r;
  logic                      free_r;
  logic [AW-1:0]             free_idx_r;
  logic                      best_r;
  logic [5:0]                best_len_r;
  logic [INTERFACE_BITS-1:0] best_if_r;
  logic [31:0]               best_hop_r;

  // entry fields from the read port
  logic                      rd_valid;
  logic [31:0]               rd_prefix;
  logic [5:0]                rd_len;
  logic [INTERFACE_BITS-1:0] rd_if;
  logic [31:0]               rd_hop;

  logic [5:0] in_len;
  logic       exact;
  logic       dest_hit;
  logic       longer;
  logic       accept;

  assign {rd_valid, rd_prefix, rd_len, rd_if, rd_hop} = mem_rdata;

  // saturate length on the incoming command
  assign in_len = (cmd.prefix_length > MAX_LEN) ? MAX_LEN : cmd.prefix_length;
  assign accept = in_valid && in_ready;

  // per-entry compare
  assign exact    = rd_valid && (rd_prefix == key_r) && (rd_len == len_r);
  assign dest_hit = rd_valid && ((addr_r & len_mask(rd_len)) == rd_prefix);
  assign longer   = !best_r || (rd_len > best_len_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SCAN_CLEAR: begin
        if (ridx_r == LastIdx) state_nxt = SCAN_IDLE;
      end
      SCAN_IDLE: begin
        if (in_valid) state_nxt = SCAN_READ;
      end
      SCAN_READ: begin
        if (ridx_r == LastIdx) state_nxt = SCAN_LAST;
      end
      SCAN_LAST: begin
        state_nxt = SCAN_DONE;
      end
      SCAN_DONE: begin
        if (out_space) state_nxt = SCAN_IDLE;
      end
      default: begin
        state_nxt = SCAN_CLEAR;
      end
    endcase
  end

  // outputs: handshake, memory port, result
  always_comb begin
    in_ready  = 1'b0;
    done      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ridx_r;
    mem_wdata = '0;
    mem_raddr = ridx_r;
    res       = '0;
    case (state_r)
      SCAN_CLEAR: begin
        mem_we = 1'b1;
      end
      SCAN_IDLE: begin
        in_ready = 1'b1;
      end
      SCAN_DONE: begin
        done = out_space;
        case (op_r)
          OP_ADD: begin
            if (hit_r) begin
              res.status = STAT_PRESENT;
            end else if (free_r) begin
              res.status = STAT_OK;
              mem_we     = out_space;
              mem_waddr  = free_idx_r;
              mem_wdata  = {1'b1, key_r, len_r, if_r, hop_r};
            end else begin
              res.status = STAT_FULL;
            end
          end
          OP_DELETE: begin
            if (hit_r) begin
              res.status = STAT_OK;
              mem_we     = out_space;
              mem_waddr  = hit_idx_r;
            end else begin
              res.status = STAT_NONE;
            end
          end
          OP_LOOKUP: begin
            res.status  = STAT_OK;
            res.matched = best_r;
            if (best_r) begin
              res.matched_length  = best_len_r;
              res.route_interface = 8'(best_if_r);
              res.route_next_hop  = best_hop_r;
            end else begin
              res.route_interface = def_if;
              res.route_next_hop  = def_hop;
            end
          end
          default: begin
            res = '0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SCAN_CLEAR;
      ridx_r   <= '0;
      rvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rvalid_r <= (state_r == SCAN_READ);
      if (state_r == SCAN_CLEAR || state_r == SCAN_READ) begin
        ridx_r <= (ridx_r == LastIdx) ? '0 : ridx_r + 1'b1;
      end
    end
  end

  // command capture and scan accumulation
  always_ff @(posedge clk) begin
    didx_r <= ridx_r;
    if (accept) begin
      op_r   <= cmd.op;
      addr_r <= cmd.address;
      key_r  <= cmd.address & len_mask(in_len);
      len_r  <= in_len;
      if_r   <= INTERFACE_BITS'(cmd.egress_interface);
      hop_r  <= cmd.hop_address;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      best_r <= 1'b0;
    end else if (rvalid_r) begin
      // first exact match
      if (exact && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= didx_r;
      end
      // lowest free slot
      if (!rd_valid && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= didx_r;
      end
      // longest matching prefix so far
      if (dest_hit && longer) begin
        best_r     <= 1'b1;
        best_len_r <= rd_len;
        best_if_r  <= rd_if;
        best_hop_r <= rd_hop;
      end
    end
  end

endmodule

// File: rtl/longest_prefix_route_table.sv
`timescale 1ns / 1ps
// longest_prefix_route_table: top level with config registers and result register
// depends on lprt_pkg, lprt_if, lprt_mem, lprt_scan
//
//   channel | direction | payload
//   in_ch   | sink      | op, address, prefix_length, egress_interface, hop_address
//   out_ch  | source    | status, matched, matched_length, route_interface, route_next_hop
//   cfg_ch  | sink      | index, data (always ready)
//
// every operation reads all TABLE_DEPTH entries through the single memory read port,
// one per cycle, then hands the result to the output register; the next command is
// taken only once the scan has finished. a successful add or delete writes back one
// entry on completion.
// after reset a clearing pass writes every entry invalid, with in_ch.ready low
// throughout. a finished result waits in the output register and the next
// command is taken meanwhile; the scan stalls in its last step only if that
// register is still full.

module longest_prefix_route_table import lprt_pkg::*; #(
  parameter int TABLE_DEPTH    = 64,
  parameter int INTERFACE_BITS = 8
) (
  input logic       clk,
  input logic       rst_n,
  lprt_in_if.sink   in_ch,
  lprt_out_if.source out_ch,
  lprt_cfg_if.sink  cfg_ch
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = 1 + 32 + 6 + INTERFACE_BITS + 32;
  localparam logic [7:0] IfMask = 8'((32'd1 << INTERFACE_BITS) - 32'd1);

  logic [7:0]   def_if_r;
  logic [31:0]  def_hop_r;
  logic         out_valid_r;
  lprt_result_t out_r;

  lprt_cmd_t     cmd;
  lprt_result_t  res;
  logic          scan_done;
  logic          out_space;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  assign cmd.op               = in_ch.op;
  assign cmd.address          = in_ch.address;
  assign cmd.prefix_length    = in_ch.prefix_length;
  assign cmd.egress_interface = in_ch.egress_interface;
  assign cmd.hop_address      = in_ch.hop_address;

  assign out_space = !out_valid_r || out_ch.ready;

  lprt_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lprt_scan #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .INTERFACE_BITS (INTERFACE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .cmd       (cmd),
    .def_if    (def_if_r),
    .def_hop   (def_hop_r),
    .out_space (out_space),
    .done      (scan_done),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // config register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_if_r  <= '0;
      def_hop_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_DEFAULT_INTERFACE: def_if_r  <= cfg_ch.data[7:0] & IfMask;
        CFG_DEFAULT_NEXT_HOP:  def_hop_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (scan_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_done) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_r.status;
  assign out_ch.matched        = out_r.matched;
  assign out_ch.matched_length = out_r.matched_length;
  assign out_ch.route_interface = out_r.route_interface;
  assign out_ch.route_next_hop = out_r.route_next_hop;

  // in_ch.ready is low right after reset, while the clearing pass runs
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ch.ready)
    else $error("command taken during clearing pass");

  // a finished scan never overwrites a pending result
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten");

  // a command transfer cannot complete in the following cycle
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !scan_done)
    else $error("result produced without a scan");

  // a matched lookup always reports success
  a_match_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.matched) |-> (out_r.status == STAT_OK))
    else $error("matched result with error status");

endmodule
